// ===== sv/mi_pkg.sv =====
// ----------------------------------------------------------------------------
// mi_pkg
// Shared widths, controller states and the command and status records that
// join the modular inverse controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mi_pkg;

	localparam int DATA_W = 32;
	localparam int MOD_W  = 31;
	localparam int CF_W   = MOD_W + 1;
	localparam int CNT_W  = $clog2(DATA_W);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RED   = 7'b0000010,
		ST_RFIN  = 7'b0000100,
		ST_CHECK = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_LFIN  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic red_fin;
		logic div_start;
		logic loop_fin;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic b_gt1;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/mi_req_if.sv =====
// ----------------------------------------------------------------------------
// mi_req_if
// Request channel: a value and its modulus with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi_req_if;
	logic                            valid;
	logic                            ready;
	logic signed [mi_pkg::DATA_W-1:0] value;
	logic        [mi_pkg::MOD_W-1:0]  modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink   (input valid, input value, input modulus, output ready);
endinterface

`default_nettype wire

// ===== sv/mi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mi_rsp_if
// Response channel: the modular inverse with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [mi_pkg::MOD_W-1:0]  inverse;

	modport source (output valid, output inverse, input ready);
	modport sink   (input valid, input inverse, output ready);
endinterface

`default_nettype wire

// ===== sv/mi_ctrl.sv =====
// ----------------------------------------------------------------------------
// mi_ctrl
// Sequencer for the modular inverse: reduction, Euclid steps and the
// response handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire mi_pkg::sts_t  sts,
	output mi_pkg::cmd_t       cmd
);

	mi_pkg::state_t state_q;
	mi_pkg::state_t state_d;
	logic           out_v_q;

	assign in_ready  = (state_q == mi_pkg::ST_IDLE);
	assign out_valid = out_v_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			mi_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mi_pkg::ST_RED;
				end
			end
			mi_pkg::ST_RED: begin
				if (sts.m_zero) begin
					state_d = mi_pkg::ST_FIN;
				end else begin
					cmd.step = 1'b1;
					if (sts.div_last) begin
						state_d = mi_pkg::ST_RFIN;
					end
				end
			end
			mi_pkg::ST_RFIN: begin
				cmd.red_fin = 1'b1;
				state_d     = mi_pkg::ST_CHECK;
			end
			mi_pkg::ST_CHECK: begin
				if (sts.b_gt1) begin
					cmd.div_start = 1'b1;
					state_d       = mi_pkg::ST_DIV;
				end else begin
					state_d = mi_pkg::ST_FIN;
				end
			end
			mi_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = mi_pkg::ST_LFIN;
				end
			end
			mi_pkg::ST_LFIN: begin
				cmd.loop_fin = 1'b1;
				state_d      = mi_pkg::ST_CHECK;
			end
			mi_pkg::ST_FIN: begin
				if (!out_v_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = mi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mi_pkg::ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mi_dp.sv =====
// ----------------------------------------------------------------------------
// mi_dp
// Datapath for the modular inverse: a bit-serial restoring divider shared
// by the reduction and the Euclid steps, with the cofactor product built
// by shift and add from the quotient bits as they appear.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_dp (
	input  wire logic                        clk,
	input  wire logic signed [mi_pkg::DATA_W-1:0] value,
	input  wire logic        [mi_pkg::MOD_W-1:0]  modulus,
	input  wire mi_pkg::cmd_t                cmd,
	output mi_pkg::sts_t                     sts,
	output logic             [mi_pkg::MOD_W-1:0]  inverse
);

	logic [mi_pkg::DATA_W-1:0] dvd_q;
	logic [mi_pkg::MOD_W-1:0]  rem_q;
	logic [mi_pkg::MOD_W-1:0]  a_q;
	logic [mi_pkg::MOD_W-1:0]  b_q;
	logic [mi_pkg::MOD_W-1:0]  m_q;
	logic [mi_pkg::CF_W-1:0]   last_q;
	logic [mi_pkg::CF_W-1:0]   before_q;
	logic [mi_pkg::CF_W-1:0]   prod_q;
	logic [mi_pkg::CNT_W-1:0]  cnt_q;
	logic                      neg_q;
	logic                      odd_q;
	logic [mi_pkg::MOD_W-1:0]  res_q;

	logic [mi_pkg::DATA_W-1:0] mag;
	logic [mi_pkg::MOD_W:0]    shifted;
	logic [mi_pkg::MOD_W+1:0]  diff;
	logic                      qbit;
	logic [mi_pkg::CF_W-1:0]   diff_out;

	assign mag      = value[mi_pkg::DATA_W-1] ? (~value + 1'b1) : value;
	assign shifted  = {rem_q, dvd_q[mi_pkg::DATA_W-1]};
	assign diff     = {1'b0, shifted} - {2'b00, b_q};
	assign qbit     = ~diff[mi_pkg::MOD_W+1];
	assign diff_out = {1'b0, m_q} - last_q;

	assign sts.m_zero   = (m_q == '0);
	assign sts.b_gt1    = (b_q > mi_pkg::MOD_W'(1));
	assign sts.div_last = (cnt_q == mi_pkg::CNT_W'(mi_pkg::DATA_W - 1));
	assign inverse      = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= modulus;
			b_q   <= modulus;
			neg_q <= value[mi_pkg::DATA_W-1];
			dvd_q <= mag;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.step) begin
			dvd_q  <= {dvd_q[mi_pkg::DATA_W-2:0], qbit};
			rem_q  <= qbit ? diff[mi_pkg::MOD_W-1:0] : shifted[mi_pkg::MOD_W-1:0];
			prod_q <= {prod_q[mi_pkg::CF_W-2:0], 1'b0} + (qbit ? last_q : '0);
			cnt_q  <= cnt_q + 1'b1;
		end
		if (cmd.red_fin) begin
			if (neg_q && (rem_q != '0)) begin
				b_q <= m_q - rem_q;
			end else begin
				b_q <= rem_q;
			end
			a_q      <= m_q;
			last_q   <= mi_pkg::CF_W'(1);
			before_q <= '0;
			odd_q    <= 1'b0;
		end
		if (cmd.div_start) begin
			dvd_q  <= {{(mi_pkg::DATA_W-mi_pkg::MOD_W){1'b0}}, a_q};
			rem_q  <= '0;
			prod_q <= '0;
			cnt_q  <= '0;
		end
		if (cmd.loop_fin) begin
			last_q   <= prod_q + before_q;
			before_q <= last_q;
			a_q      <= b_q;
			b_q      <= rem_q;
			odd_q    <= ~odd_q;
		end
		if (cmd.fin) begin
			if (m_q == '0) begin
				res_q <= '0;
			end else if (odd_q) begin
				res_q <= diff_out[mi_pkg::MOD_W-1:0];
			end else begin
				res_q <= last_q[mi_pkg::MOD_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/modular_inverse.sv =====
// ----------------------------------------------------------------------------
// modular_inverse
// Inverse of a signed value modulo a positive modulus by Euclid's extended
// remainder sequence.
//
// A request carries value (32-bit two's complement) and modulus (31 bits).
// The response carries inverse, in 0..modulus; a value that reduces to zero
// gives 1 and a zero modulus gives 0. Inputs that are not coprime give
// whatever the sequence ends with, with no flag.
// Both channels use valid/ready; a request is taken only while the block
// is idle. The work runs through one bit-serial restoring divider, one
// quotient bit per cycle: the divider first reduces the value, then each
// Euclid step takes a check, a full-width divide and a cofactor update, and
// a last check and the result write close the item. A zero modulus skips
// the reduction and goes straight to the result write.
// The result sits in an output register, so a new request is accepted
// while an earlier result waits; if the receiver stalls, the next item
// holds at its end until that register is free. Reset clears the sequencer
// and the response valid; no other clearing is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse (
	input  wire logic clk,
	input  wire logic arst_n,
	mi_req_if.sink    req,
	mi_rsp_if.source  rsp
);

	mi_pkg::cmd_t cmd;
	mi_pkg::sts_t sts;
	logic         in_ready;
	logic         out_valid;

	mi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mi_dp u_dp (
		.clk     (clk),
		.value   (req.value),
		.modulus (req.modulus),
		.cmd     (cmd),
		.sts     (sts),
		.inverse (rsp.inverse)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ===== dv/modular_inverse_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_inverse_tb
// Self-checking testbench for the Euclid modular inverse block.
//
// A directed set covers the field extremes, the zero value, unit and zero
// moduli, non-coprime pairs and a worst-case Fibonacci pair. Random requests
// follow, mostly with narrow moduli and some at full width. A behavioral
// predictor computes each expected inverse when its request is accepted, and
// a monitor compares every response in order against those predictions while
// both channels run through three pacing phases, the last one unthrottled.
// ----------------------------------------------------------------------------

module modular_inverse_tb;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 50;
	localparam int ITEMS_PER_PHASE = 450;

	typedef struct {
		logic signed [mi_pkg::DATA_W-1:0] value;
		logic        [mi_pkg::MOD_W-1:0]  modulus;
	} inv_req_t;

	logic clk = 1'b0;
	logic arst_n;

	mi_req_if req_ch ();
	mi_rsp_if rsp_ch ();

	modular_inverse dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	inv_req_t                   pending_req_q[$];
	logic [mi_pkg::MOD_W-1:0]   inverse_exp_q[$];
	int                         n_queued = 0;
	int                         n_req = 0;
	int                         n_rsp = 0;
	int                         n_err = 0;
	int                         n_zero_mod = 0;
	int                         n_wide_mod = 0;
	int                         stall_cnt = 0;
	int unsigned                snd_idle_pct = 10;
	int unsigned                rcv_idle_pct = 58;

	always #5 clk = ~clk;

	function automatic logic [mi_pkg::MOD_W-1:0] predict_inverse(
		logic signed [mi_pkg::DATA_W-1:0] value,
		logic        [mi_pkg::MOD_W-1:0]  modulus
	);
		longint unsigned m, dividend, divisor, cf_cur, cf_prev, quo, rem, nxt, mag;
		bit odd;
		m = modulus;
		if (m == 0)
			return '0;
		if (value < 0) begin
			mag = longint'(-longint'(value));
			rem = mag % m;
			divisor = (rem == 0) ? 0 : m - rem;
		end else begin
			divisor = longint'(value) % m;
		end
		dividend = m;
		cf_cur = 1;
		cf_prev = 0;
		odd = 1'b0;
		while (divisor > 1) begin
			quo = dividend / divisor;
			rem = dividend - quo * divisor;
			nxt = quo * cf_cur + cf_prev;
			cf_prev = cf_cur;
			cf_cur = nxt;
			dividend = divisor;
			divisor = rem;
			odd = ~odd;
		end
		return odd ? mi_pkg::MOD_W'(m - cf_cur) : mi_pkg::MOD_W'(cf_cur);
	endfunction

	task automatic queue_request(logic signed [mi_pkg::DATA_W-1:0] value,
			logic [mi_pkg::MOD_W-1:0] modulus);
		inv_req_t item;
		item.value = value;
		item.modulus = modulus;
		pending_req_q.push_back(item);
		n_queued++;
		if (modulus == 0)
			n_zero_mod++;
		if (modulus >= (1 << 20))
			n_wide_mod++;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_req
		inv_req_t item;
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.value   <= '0;
			req_ch.modulus <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				inverse_exp_q.push_back(predict_inverse(req_ch.value, req_ch.modulus));
				n_req <= n_req + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_req_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					item = pending_req_q.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.value   <= item.value;
					req_ch.modulus <= item.modulus;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin : check_rsp
		logic [mi_pkg::MOD_W-1:0] exp_inverse;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (n_rsp >= n_req) begin
				$display("%0t: unexpected response, expected none, actual inverse %0d",
					$time, rsp_ch.inverse);
				n_err++;
			end else begin
				exp_inverse = inverse_exp_q.pop_front();
				if (rsp_ch.inverse !== exp_inverse) begin
					$display("%0t: inverse mismatch, expected %0d, actual %0d",
						$time, exp_inverse, rsp_ch.inverse);
					n_err++;
				end
				n_rsp <= n_rsp + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL modular_inverse");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned              kind;
		int unsigned              width;
		logic [mi_pkg::MOD_W-1:0] mod;
		logic signed [31:0]       val;
		longint                   tmp;
		int                       n_directed;

		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.value   = '0;
		req_ch.modulus = '0;
		rsp_ch.ready   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		queue_request(32'sd0, 31'd7);
		queue_request(32'sd5, 31'd1);
		queue_request(32'sh8000_0000, 31'd1);
		queue_request(32'sd1, 31'd0);
		queue_request(32'sh8000_0000, 31'd0);
		queue_request(32'sh7fff_ffff, 31'h7fff_ffff);
		queue_request(32'sh8000_0000, 31'h7fff_ffff);
		queue_request(32'sd1, 31'h7fff_ffff);
		queue_request(-32'sd1, 31'h7fff_ffff);
		queue_request(32'sd3, 31'd7);
		queue_request(-32'sd3, 31'd7);
		queue_request(-32'sd7, 31'd7);
		queue_request(32'sd1134903170, 31'd1836311903);
		queue_request(-32'sd1134903170, 31'd1836311903);
		queue_request(32'sd6, 31'd9);
		queue_request(-32'sd6, 31'd9);
		queue_request(32'sd12, 31'd18);
		queue_request(32'sd2, 31'd4);
		queue_request(32'sd65536, 31'd1000000007);
		queue_request(32'sh8000_0000, 31'd2);
		queue_request(32'sh7fff_ffff, 31'd2);
		queue_request(32'sd1, 31'd2);
		queue_request(32'sd123456789, 31'h4000_0000);
		n_directed = n_queued;

		// Hold further requests until every directed response is back.
		while (n_rsp != n_queued)
			@(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			snd_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 58 : 0;
			rcv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 10 : 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				kind = $urandom_range(99);
				if (kind < 1) begin
					mod = '0;
				end else if (kind < 8) begin
					case ($urandom_range(3))
						0: mod = 31'h7fff_ffff;
						1: mod = 31'd1000000007;
						2: mod = 31'd65521;
						default: mod = 31'd251;
					endcase
				end else begin
					width = (kind < 75) ? $urandom_range(1, 12) : $urandom_range(13, 31);
					mod = mi_pkg::MOD_W'(($urandom & ((32'd1 << width) - 1))
						| (32'd1 << (width - 1)));
				end
				kind = $urandom_range(99);
				if (kind < 50) begin
					val = $urandom;
				end else if (kind < 80) begin
					tmp = longint'($urandom_range(0, 2 * mod)) - longint'(mod);
					val = 32'(tmp);
				end else if (kind < 90) begin
					tmp = longint'($urandom_range(0, 7)) * longint'(mod);
					val = ($urandom_range(1) == 1) ? 32'(tmp) : 32'(-tmp);
				end else begin
					tmp = longint'($urandom_range(2, 6)) * longint'($urandom_range(0, 4095));
					val = ($urandom_range(1) == 1) ? 32'(tmp) : 32'(-tmp);
				end
				queue_request(val, mod);
			end
			while (n_req != n_queued)
				@(posedge clk);
		end

		while (n_rsp != n_queued)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d directed) over three pacing phases;",
			n_queued, n_directed);
		$display("%0d had a zero modulus, %0d a modulus of 21 bits or more, %0d errors.",
			n_zero_mod, n_wide_mod, n_err);
		if (n_err == 0)
			$display("PASS modular_inverse");
		else
			$display("FAIL modular_inverse");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mi_pkg.sv
sv/mi_req_if.sv
sv/mi_rsp_if.sv
sv/mi_ctrl.sv
sv/mi_dp.sv
sv/modular_inverse.sv
dv/modular_inverse_tb.sv
